/* rtl/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every sampled edge outside reset
`define RDP_ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rdp check failed");

// consequent holds in the cycle after the antecedent
`define RDP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rdp check failed");

// consequent holds after the antecedent, at a later edge than in RDP_ASSERT_NEXT
`define RDP_ASSERT_LATER(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
        else $error("rdp check failed");

`endif

/* rtl/rdp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_pkg
// types, codes and sizes shared by the row displacement packer
// ----------------------------------------------------------------------------
package rdp_pkg;

    localparam int DEF_MAX_ROWS    = 32;
    localparam int DEF_MAX_COLS    = 32;
    localparam int DEF_MAX_SLOTS   = 2048;
    localparam int DEF_ENTRY_WIDTH = 16;

    localparam int REQ_W      = 2;
    localparam int IDX_W      = 5;
    localparam int SLOT_IN_W  = 11;
    localparam int VAL_W      = 16;
    localparam int BASE_W     = 11;
    localparam int OWNER_W    = 6;
    localparam int LEN_W      = 11;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_INSIG = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd2;

    typedef enum logic [1:0] {
        REQ_LOAD,
        REQ_PACK,
        REQ_BASE,
        REQ_SLOT
    } t_req;

    typedef enum logic [1:0] {
        EM_NONE,
        EM_PLAIN,
        EM_BASE,
        EM_SLOT
    } t_emit;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOAD,
        ST_BASE,
        ST_SLOT_RD,
        ST_SLOT_OUT,
        ST_PK_INIT,
        ST_CNT_RD,
        ST_CNT_ACC,
        ST_SORT_LD,
        ST_SORT_CMP,
        ST_SWEEP,
        ST_PL_START,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FIT_RD,
        ST_FIT_CHK,
        ST_WR_RD,
        ST_WR,
        ST_NEXT_ROW,
        ST_FINISH,
        ST_PK_OUT
    } t_state;

    typedef struct packed {
        logic  cap_req;
        logic  mat_we;
        logic  mat_cur;
        logic  pack_init;
        logic  cnt_step;
        logic  sort_load;
        logic  sort_step;
        logic  sort_wb;
        logic  sweep_wr;
        logic  pl_start;
        logic  scan_chk;
        logic  fit_adv;
        logic  fit_fail;
        logic  wr_init;
        logic  wr_step;
        logic  next_row;
        logic  finish;
        t_emit emit;
    } t_cmd;

    typedef struct packed {
        logic col_last;
        logic row_last;
        logic dims_zero;
        logic j_end;
        logic sweep_last;
        logic any_n;
        logic cur_sig;
        logic s_over;
        logic d_over;
        logic occ_hit;
        logic c_is_last;
    } t_sts;

endpackage

/* rtl/rdp_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rdp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/rdp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_ctrl
// sequencer for requests and the pack walk
// ----------------------------------------------------------------------------
module rdp_ctrl
    import rdp_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [REQ_W-1:0] i_req_type,
    input  t_sts             i_sts,
    output logic             o_busy,
    output t_cmd             o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    case (t_req'(i_req_type))
                        REQ_LOAD: n_state = ST_LOAD;
                        REQ_PACK: n_state = ST_PK_INIT;
                        REQ_BASE: n_state = ST_BASE;
                        REQ_SLOT: n_state = ST_SLOT_RD;
                        default:  n_state = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:     n_state = ST_IDLE;
            ST_BASE:     n_state = ST_IDLE;
            ST_SLOT_RD:  n_state = ST_SLOT_OUT;
            ST_SLOT_OUT: n_state = ST_IDLE;
            ST_PK_INIT:  n_state = i_sts.dims_zero ? ST_SWEEP : ST_CNT_RD;
            ST_CNT_RD:   n_state = ST_CNT_ACC;
            ST_CNT_ACC: begin
                if (i_sts.col_last && i_sts.row_last) begin
                    n_state = ST_SORT_LD;
                end else begin
                    n_state = ST_CNT_RD;
                end
            end
            ST_SORT_LD:  n_state = ST_SORT_CMP;
            ST_SORT_CMP: begin
                if (i_sts.j_end) begin
                    n_state = i_sts.row_last ? ST_SWEEP : ST_SORT_LD;
                end
            end
            ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = i_sts.dims_zero ? ST_FINISH : ST_PL_START;
                end
            end
            ST_PL_START: n_state = ST_SCAN_RD;
            ST_SCAN_RD:  n_state = ST_SCAN_CHK;
            ST_SCAN_CHK: begin
                if (i_sts.col_last) begin
                    n_state = i_sts.any_n ? ST_FIT_RD : ST_NEXT_ROW;
                end else begin
                    n_state = ST_SCAN_RD;
                end
            end
            ST_FIT_RD: begin
                if (i_sts.cur_sig) begin
                    if (i_sts.s_over) begin
                        n_state = i_sts.d_over ? ST_NEXT_ROW : ST_FIT_RD;
                    end else begin
                        n_state = ST_FIT_CHK;
                    end
                end
            end
            ST_FIT_CHK: begin
                if (i_sts.occ_hit) begin
                    n_state = i_sts.d_over ? ST_NEXT_ROW : ST_FIT_RD;
                end else if (i_sts.c_is_last) begin
                    n_state = ST_WR_RD;
                end else begin
                    n_state = ST_FIT_RD;
                end
            end
            ST_WR_RD:    n_state = ST_WR;
            ST_WR:       n_state = i_sts.c_is_last ? ST_NEXT_ROW : ST_WR_RD;
            ST_NEXT_ROW: n_state = i_sts.row_last ? ST_FINISH : ST_PL_START;
            ST_FINISH:   n_state = ST_PK_OUT;
            ST_PK_OUT:   n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.emit = EM_NONE;
        case (r_state)
            ST_IDLE:     o_cmd.cap_req = i_start;
            ST_LOAD: begin
                o_cmd.mat_we = 1'b1;
                o_cmd.emit   = EM_PLAIN;
            end
            ST_BASE:     o_cmd.emit = EM_BASE;
            ST_SLOT_RD:  o_cmd.emit = EM_NONE;
            ST_SLOT_OUT: o_cmd.emit = EM_SLOT;
            ST_PK_INIT:  o_cmd.pack_init = 1'b1;
            ST_CNT_RD:   o_cmd.mat_cur = 1'b0;
            ST_CNT_ACC:  o_cmd.cnt_step = 1'b1;
            ST_SORT_LD:  o_cmd.sort_load = 1'b1;
            ST_SORT_CMP: begin
                o_cmd.sort_wb   = i_sts.j_end;
                o_cmd.sort_step = !i_sts.j_end;
            end
            ST_SWEEP:    o_cmd.sweep_wr = 1'b1;
            ST_PL_START: o_cmd.pl_start = 1'b1;
            ST_SCAN_RD:  o_cmd.mat_cur = 1'b1;
            ST_SCAN_CHK: begin
                o_cmd.mat_cur  = 1'b1;
                o_cmd.scan_chk = 1'b1;
            end
            ST_FIT_RD: begin
                o_cmd.fit_adv  = !i_sts.cur_sig;
                o_cmd.fit_fail = i_sts.cur_sig && i_sts.s_over;
            end
            ST_FIT_CHK: begin
                o_cmd.fit_fail = i_sts.occ_hit;
                o_cmd.wr_init  = !i_sts.occ_hit && i_sts.c_is_last;
                o_cmd.fit_adv  = !i_sts.occ_hit && !i_sts.c_is_last;
            end
            ST_WR_RD:    o_cmd.mat_cur = 1'b1;
            ST_WR: begin
                o_cmd.mat_cur = 1'b1;
                o_cmd.wr_step = 1'b1;
            end
            ST_NEXT_ROW: o_cmd.next_row = 1'b1;
            ST_FINISH:   o_cmd.finish = 1'b1;
            ST_PK_OUT:   o_cmd.emit = EM_PLAIN;
            default:     o_cmd.emit = EM_NONE;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

/* rtl/rdp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_datapath
// table store, row tables, packed vectors and result registers
// ----------------------------------------------------------------------------
module rdp_datapath
    import rdp_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [IDX_W-1:0]      i_row,
    input  logic [IDX_W-1:0]      i_col,
    input  logic [VAL_W-1:0]      i_entry_value,
    input  logic [SLOT_IN_W-1:0]  i_slot,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [BASE_W-1:0]     o_row_base,
    output logic [VAL_W-1:0]      o_slot_value,
    output logic [OWNER_W-1:0]    o_slot_owner,
    output logic [LEN_W-1:0]      o_check_length,
    output logic [LEN_W-1:0]      o_vector_length
);

    localparam int RAW = $clog2(MAX_ROWS);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CAW = $clog2(MAX_COLS);
    localparam int CCW = $clog2(MAX_COLS + 1);
    localparam int SAW = $clog2(MAX_SLOTS);
    localparam int MAT_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int MAW = $clog2(MAT_DEPTH);
    localparam int EW  = ENTRY_WIDTH;

    // configuration
    logic [VAL_W-1:0] r_ins;
    logic [CNT_W-1:0] r_row_count;
    logic [CNT_W-1:0] r_col_count;

    // latched request
    logic [IDX_W-1:0]     r_row;
    logic [IDX_W-1:0]     r_col;
    logic [VAL_W-1:0]     r_val;
    logic [SLOT_IN_W-1:0] r_slot;

    // walk state
    logic [RCW-1:0]      r_i;
    logic [RCW-1:0]      r_j;
    logic [CCW-1:0]      r_c;
    logic [CCW-1:0]      r_acc;
    logic [CCW-1:0]      r_wi;
    logic [RAW-1:0]      r_oi;
    logic [RAW-1:0]      r_cur;
    logic                r_any;
    logic [CAW-1:0]      r_first;
    logic [CAW-1:0]      r_last;
    logic [MAX_COLS-1:0] r_sig;
    logic [SAW-1:0]      r_d;
    logic [SAW-1:0]      r_sw;
    logic [SAW-1:0]      r_maxbase;
    logic [SAW-1:0]      r_maxs;
    logic [SAW-1:0]      r_len0;
    logic [SAW-1:0]      r_len1;

    logic [CCW-1:0] r_weight [MAX_ROWS];
    logic [RAW-1:0] r_order  [MAX_ROWS];
    logic [SAW-1:0] r_base   [MAX_ROWS];

    // results
    logic                r_valid;
    logic [BASE_W-1:0]   r_o_base;
    logic [VAL_W-1:0]    r_o_val;
    logic [OWNER_W-1:0]  r_o_own;
    logic [LEN_W-1:0]    r_o_chk;
    logic [LEN_W-1:0]    r_o_vlen;

    // derived values
    logic [RCW-1:0]     rows_e;
    logic [CCW-1:0]     cols_e;
    logic [EW+15:0]     ins_wide;
    logic [EW-1:0]      ins_e;
    logic [EW+15:0]     val_wide;
    logic [EW-1:0]      val_e;
    logic [RCW+5:0]     rows_own_wide;
    logic [RAW+5:0]     cur_own_wide;
    logic [RAW+4:0]     row_wide;
    logic [RAW-1:0]     row_idx;
    logic [SAW+10:0]    slot_wide;
    logic [SAW-1:0]     slot_addr;
    logic [SAW+10:0]    base_wide;
    logic [SAW+10:0]    len0_wide;
    logic [SAW+10:0]    len1_wide;
    logic [EW+15:0]     rdv_wide;
    logic [CAW-1:0]     c_idx;
    logic [RAW-1:0]     i_idx;
    logic [RAW-1:0]     j_idx;
    logic [RAW-1:0]     mat_row;
    logic               mat_sig;
    logic [CCW-1:0]     acc_n;
    int                 s_int;
    int                 len_int;
    logic               slot_in;

    // memory ports
    logic [MAW-1:0]     mat_waddr;
    logic [MAW-1:0]     mat_raddr;
    logic               mat_we;
    logic [EW-1:0]      mat_rdata;
    logic               vec_we;
    logic [SAW-1:0]     vec_waddr;
    logic [SAW-1:0]     occ_raddr;
    logic [0:0]         occ_wdata;
    logic [0:0]         occ_rdata;
    logic [EW-1:0]      vv_wdata;
    logic [EW-1:0]      vv_rdata;
    logic [OWNER_W-1:0] ov_wdata;
    logic [OWNER_W-1:0] ov_rdata;

    assign rows_e = (int'(r_row_count) > MAX_ROWS) ? RCW'(MAX_ROWS) : RCW'(r_row_count);
    assign cols_e = (int'(r_col_count) > MAX_COLS) ? CCW'(MAX_COLS) : CCW'(r_col_count);

    assign ins_wide      = {{EW{1'b0}}, r_ins};
    assign ins_e         = ins_wide[EW-1:0];
    assign val_wide      = {{EW{1'b0}}, r_val};
    assign val_e         = val_wide[EW-1:0];
    assign rows_own_wide = {{OWNER_W{1'b0}}, rows_e};
    assign cur_own_wide  = {{OWNER_W{1'b0}}, r_cur};
    assign row_wide      = {{RAW{1'b0}}, r_row};
    assign row_idx       = row_wide[RAW-1:0];
    assign slot_wide     = {{SAW{1'b0}}, r_slot};
    assign slot_addr     = slot_wide[SAW-1:0];
    assign base_wide     = {{BASE_W{1'b0}}, r_base[row_idx]};
    assign len0_wide     = {{LEN_W{1'b0}}, r_len0};
    assign len1_wide     = {{LEN_W{1'b0}}, r_len1};
    assign rdv_wide      = {{VAL_W{1'b0}}, vv_rdata};

    assign c_idx   = r_c[CAW-1:0];
    assign i_idx   = r_i[RAW-1:0];
    assign j_idx   = r_j[RAW-1:0];
    assign mat_row = i_cmd.mat_cur ? r_cur : i_idx;
    assign mat_sig = (mat_rdata != ins_e);
    assign acc_n   = r_acc + CCW'(mat_sig);
    assign s_int   = int'(r_d) + int'(r_c);
    assign len_int = int'(r_maxbase) + int'(cols_e);
    assign slot_in = (int'(r_slot) < int'(r_len0)) && (int'(r_slot) < MAX_SLOTS);

    // status to the sequencer
    assign o_sts.col_last   = (int'(r_c) + 1 == int'(cols_e));
    assign o_sts.row_last   = (int'(r_i) + 1 >= int'(rows_e));
    assign o_sts.dims_zero  = (rows_e == '0) || (cols_e == '0);
    assign o_sts.j_end      = (int'(r_j) >= int'(rows_e));
    assign o_sts.sweep_last = (int'(r_sw) == MAX_SLOTS - 1);
    assign o_sts.any_n      = r_any | mat_sig;
    assign o_sts.cur_sig    = r_sig[c_idx];
    assign o_sts.s_over     = (s_int >= MAX_SLOTS);
    assign o_sts.d_over     = (int'(r_d) + 1 + int'(r_first) >= MAX_SLOTS);
    assign o_sts.occ_hit    = occ_rdata[0];
    assign o_sts.c_is_last  = (c_idx == r_last);

    // table store
    assign mat_we    = i_cmd.mat_we && (int'(r_row) < MAX_ROWS) && (int'(r_col) < MAX_COLS);
    assign mat_waddr = MAW'(int'(r_row) * MAX_COLS + int'(r_col));
    assign mat_raddr = MAW'(int'(mat_row) * MAX_COLS + int'(c_idx));

    rdp_ram #(.WIDTH(EW), .DEPTH(MAT_DEPTH)) u_mat (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (val_e),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    // packed vectors, cleared by the sweep and filled while placing
    assign vec_we    = i_cmd.sweep_wr || (i_cmd.wr_step && r_sig[c_idx]);
    assign vec_waddr = i_cmd.sweep_wr ? r_sw : SAW'(s_int);
    assign occ_raddr = SAW'(s_int);
    assign occ_wdata = i_cmd.sweep_wr ? 1'b0 : 1'b1;
    assign vv_wdata  = i_cmd.sweep_wr ? ins_e : mat_rdata;
    assign ov_wdata  = i_cmd.sweep_wr ? rows_own_wide[OWNER_W-1:0]
                                      : cur_own_wide[OWNER_W-1:0];

    rdp_ram #(.WIDTH(1), .DEPTH(MAX_SLOTS)) u_occ (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (occ_wdata),
        .i_raddr (occ_raddr),
        .o_rdata (occ_rdata)
    );

    rdp_ram #(.WIDTH(EW), .DEPTH(MAX_SLOTS)) u_val (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (vv_wdata),
        .i_raddr (slot_addr),
        .o_rdata (vv_rdata)
    );

    rdp_ram #(.WIDTH(OWNER_W), .DEPTH(MAX_SLOTS)) u_own (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (ov_wdata),
        .i_raddr (slot_addr),
        .o_rdata (ov_rdata)
    );

    // request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_req) begin
            r_row  <= i_row;
            r_col  <= i_col;
            r_val  <= i_entry_value;
            r_slot <= i_slot;
        end
    end

    // walk registers without reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.sort_load) begin
            r_wi <= r_weight[i_idx];
            r_oi <= r_order[i_idx];
        end else if (i_cmd.sort_step && (r_wi < r_weight[j_idx])) begin
            r_wi <= r_weight[j_idx];
            r_oi <= r_order[j_idx];
        end
        if (i_cmd.pl_start) begin
            r_cur <= r_order[i_idx];
            r_any <= 1'b0;
            r_sig <= '0;
        end
        if (i_cmd.scan_chk) begin
            r_sig[c_idx] <= mat_sig;
            if (mat_sig) begin
                if (!r_any) begin
                    r_first <= c_idx;
                end
                r_last <= c_idx;
                r_any  <= 1'b1;
            end
        end
    end

    // control, configuration and row tables
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ins       <= '0;
            r_row_count <= CNT_W'(32);
            r_col_count <= CNT_W'(32);
            r_i         <= '0;
            r_j         <= '0;
            r_c         <= '0;
            r_acc       <= '0;
            r_d         <= '0;
            r_sw        <= '0;
            r_maxbase   <= '0;
            r_maxs      <= '0;
            r_len0      <= '0;
            r_len1      <= '0;
            r_valid     <= 1'b0;
            for (int k = 0; k < MAX_ROWS; k++) begin
                r_weight[k] <= '0;
                r_order[k]  <= RAW'(k);
                r_base[k]   <= '0;
            end
        end else begin
            r_valid <= (i_cmd.emit != EM_NONE);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_INSIG: r_ins       <= i_cfg_data;
                    CFG_ROWS:  r_row_count <= i_cfg_data[CNT_W-1:0];
                    CFG_COLS:  r_col_count <= i_cfg_data[CNT_W-1:0];
                    default:   r_ins       <= r_ins;
                endcase
            end
            if (i_cmd.pack_init) begin
                r_i       <= '0;
                r_c       <= '0;
                r_acc     <= '0;
                r_sw      <= '0;
                r_maxbase <= '0;
                r_maxs    <= '0;
                for (int k = 0; k < MAX_ROWS; k++) begin
                    r_weight[k] <= '0;
                    r_order[k]  <= RAW'(k);
                    r_base[k]   <= '0;
                end
            end
            if (i_cmd.cnt_step) begin
                if (o_sts.col_last) begin
                    r_weight[i_idx] <= acc_n;
                    r_acc           <= '0;
                    r_c             <= '0;
                    r_i             <= o_sts.row_last ? '0 : r_i + 1'b1;
                end else begin
                    r_acc <= acc_n;
                    r_c   <= r_c + 1'b1;
                end
            end
            if (i_cmd.sort_load) begin
                r_j <= r_i + 1'b1;
            end
            if (i_cmd.sort_step) begin
                if (r_wi < r_weight[j_idx]) begin
                    r_weight[j_idx] <= r_wi;
                    r_order[j_idx]  <= r_oi;
                end
                r_j <= r_j + 1'b1;
            end
            if (i_cmd.sort_wb) begin
                r_weight[i_idx] <= r_wi;
                r_order[i_idx]  <= r_oi;
                r_i             <= r_i + 1'b1;
            end
            if (i_cmd.sweep_wr) begin
                r_sw <= r_sw + 1'b1;
                r_i  <= '0;
            end
            if (i_cmd.pl_start) begin
                r_c <= '0;
            end
            if (i_cmd.scan_chk) begin
                if (o_sts.col_last) begin
                    r_c <= r_any ? CCW'(r_first) : r_c;
                    r_d <= '0;
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            if (i_cmd.fit_adv) begin
                r_c <= r_c + 1'b1;
            end
            if (i_cmd.fit_fail) begin
                r_d <= r_d + 1'b1;
                r_c <= CCW'(r_first);
            end
            if (i_cmd.wr_init) begin
                r_c <= CCW'(r_first);
            end
            if (i_cmd.wr_step) begin
                // slot one below the top is never trimmed off, the top slot is
                if (r_sig[c_idx] && (s_int != MAX_SLOTS - 1)
                        && (s_int + 1 > int'(r_maxs))) begin
                    r_maxs <= SAW'(s_int + 1);
                end
                if (o_sts.c_is_last) begin
                    r_base[r_cur] <= r_d;
                    if (r_d > r_maxbase) begin
                        r_maxbase <= r_d;
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                end
            end
            if (i_cmd.next_row) begin
                r_i <= r_i + 1'b1;
            end
            if (i_cmd.finish) begin
                r_len0 <= (len_int > MAX_SLOTS - 1) ? SAW'(MAX_SLOTS - 1) : SAW'(len_int);
                r_len1 <= r_maxs;
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit != EM_NONE) begin
            r_o_chk  <= len0_wide[LEN_W-1:0];
            r_o_vlen <= len1_wide[LEN_W-1:0];
        end
        case (i_cmd.emit)
            EM_PLAIN: begin
                r_o_base <= '0;
                r_o_val  <= '0;
                r_o_own  <= '0;
            end
            EM_BASE: begin
                r_o_base <= (int'(r_row) < MAX_ROWS) ? base_wide[BASE_W-1:0] : '0;
                r_o_val  <= '0;
                r_o_own  <= '0;
            end
            EM_SLOT: begin
                r_o_base <= '0;
                r_o_val  <= slot_in ? rdv_wide[VAL_W-1:0] : r_ins;
                r_o_own  <= slot_in ? ov_rdata : r_row_count;
            end
            default: begin
                r_o_base <= r_o_base;
            end
        endcase
    end

    assign o_valid         = r_valid;
    assign o_row_base      = r_o_base;
    assign o_slot_value    = r_o_val;
    assign o_slot_owner    = r_o_own;
    assign o_check_length  = r_o_chk;
    assign o_vector_length = r_o_vlen;

endmodule

/* rtl/row_displacement_pack.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_displacement_pack
// first-fit row displacement packer for a sparse table
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                  payload
// request   in         start high, busy low       i_req_type i_row i_col
//                                                 i_entry_value i_slot
// result    out        o_valid, one cycle         o_row_base o_slot_value
//                                                 o_slot_owner o_check_length
//                                                 o_vector_length
// config    in         i_cfg_we                   i_cfg_index i_cfg_data
//
// load and base read: the result follows ST_LOAD or ST_BASE, busy already low
// slot read: ST_SLOT_RD reads the registered vector ram, ST_SLOT_OUT emits
// pack: a count pass, a sort by weight, a sweep, then the fit search per row;
//   count pass and column scan read, then check each entry; the sort makes one
//   compare a cycle; a fit probe skips one column a cycle and reads, then checks
//   each significant entry; the write reads, then writes each column of the
//   row's span; each pack clears the vectors one slot a cycle
// reset is synchronous and active low; no clearing pass follows it
// results cannot be held off: o_valid marks each for one cycle only
//
module row_displacement_pack
    import rdp_pkg::*;
#(
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_COLS    = DEF_MAX_COLS,
    parameter int MAX_SLOTS   = DEF_MAX_SLOTS,
    parameter int ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [IDX_W-1:0]      i_row,
    input  logic [IDX_W-1:0]      i_col,
    input  logic signed [VAL_W-1:0] i_entry_value,
    input  logic [SLOT_IN_W-1:0]  i_slot,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_valid,
    output logic [BASE_W-1:0]     o_row_base,
    output logic signed [VAL_W-1:0] o_slot_value,
    output logic [OWNER_W-1:0]    o_slot_owner,
    output logic [LEN_W-1:0]      o_check_length,
    output logic [LEN_W-1:0]      o_vector_length
);

    // command and status between sequencer and datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: request decode and the pack walk
    rdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_sts      (sts),
        .o_busy     (busy),
        .o_cmd      (cmd)
    );

    // datapath: table store, row tables, packed vectors, result registers
    rdp_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_SLOTS   (MAX_SLOTS),
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_row           (i_row),
        .i_col           (i_col),
        .i_entry_value   (i_entry_value),
        .i_slot          (i_slot),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_valid         (o_valid),
        .o_row_base      (o_row_base),
        .o_slot_value    (o_slot_value),
        .o_slot_owner    (o_slot_owner),
        .o_check_length  (o_check_length),
        .o_vector_length (o_vector_length)
    );

endmodule

/* rtl/rdp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdp_checker
// port level checks on the row displacement packer
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rdp_checker
    import rdp_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [REQ_W-1:0] i_req_type,
    input logic             o_valid,
    input logic [LEN_W-1:0] o_check_length,
    input logic [LEN_W-1:0] o_vector_length
);

    logic accept;
    logic load_acc;

    assign accept   = start && !busy;
    assign load_acc = accept && (i_req_type == REQ_LOAD);

    // an accepted item keeps the block busy next cycle
    `RDP_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, busy)
    // a result strobe lasts one cycle
    `RDP_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, o_valid, !o_valid)
    // trimmed length never exceeds the check length
    `RDP_ASSERT_ALWAYS(a_len_order, i_clk, i_rst_n,
        !o_valid || (o_vector_length <= o_check_length))
    // a load answers through ST_LOAD and the registered valid flag
    `RDP_ASSERT_LATER(a_load_latency, i_clk, i_rst_n, load_acc, o_valid)

endmodule

bind row_displacement_pack rdp_checker u_rdp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .i_req_type      (i_req_type),
    .o_valid         (o_valid),
    .o_check_length  (o_check_length),
    .o_vector_length (o_vector_length)
);
